[hw/rtl/sdf_pkg.sv]
// shared types and constants for the sequence duplicate filter
package sdf_pkg;
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_EVICT,
        ST_OUT
    } t_state;
    localparam int unsigned KEY_W = 64;
    localparam int unsigned FILL_W = 7;
    localparam int unsigned DUP_W = 32;
endpackage

[hw/rtl/sequence_duplicate_filter.sv]
// sequence number duplicate filter: sorted set kept in one ram
// a new number is found by a scan and placed by an insert shift; both spend a ram read and then
// a compare or write per entry; a duplicate ends the scan at its slot; eviction copies each
// surviving entry down by CACHE_SIZE/4, again with a ram read and a write per entry
// one item at a time; a finished result moves to the output register and frees the input
// reset (synchronous, active low) clears the count and duplicate counter; ram is not cleared
module sequence_duplicate_filter #(
    parameter int unsigned CACHE_SIZE = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sdf_pkg::KEY_W-1:0]   i_sequence_req,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_is_new,
    output logic                        o_evicted,
    output logic [sdf_pkg::FILL_W-1:0]  o_fill_level,
    output logic [sdf_pkg::DUP_W-1:0]   o_duplicates_seen
);
    import sdf_pkg::*;

    localparam int unsigned DEPTH = CACHE_SIZE + 1;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned EVICT = CACHE_SIZE / 4;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;   // scan / shift / evict pointer
    logic [KEY_W-1:0] r_key, n_key;
    logic [KEY_W-1:0] r_carry, n_carry;
    logic r_rd_pend, n_rd_pend;
    logic [DUP_W-1:0] r_dup, n_dup;
    logic r_ov, n_ov;
    logic r_new, n_new;
    logic r_ev, n_ev;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic r_out_new, n_out_new;
    logic r_out_ev, n_out_ev;
    logic [FILL_W-1:0] r_out_fill, n_out_fill;
    logic [DUP_W-1:0] r_out_dup, n_out_dup;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [KEY_W-1:0] wdata, rdata;

    sdf_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_dup     <= '0;
            r_ov      <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_dup     <= n_dup;
            r_ov      <= n_ov;
            r_rd_pend <= n_rd_pend;
        end
        r_idx      <= n_idx;
        r_key      <= n_key;
        r_carry    <= n_carry;
        r_new      <= n_new;
        r_ev       <= n_ev;
        r_fill     <= n_fill;
        r_out_new  <= n_out_new;
        r_out_ev   <= n_out_ev;
        r_out_fill <= n_out_fill;
        r_out_dup  <= n_out_dup;
    end

    assign o_ready           = (r_state == ST_IDLE);
    assign o_valid           = r_ov;
    assign o_is_new          = r_out_new;
    assign o_evicted         = r_out_ev;
    assign o_fill_level      = r_out_fill;
    assign o_duplicates_seen = r_out_dup;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_key      = r_key;
        n_carry    = r_carry;
        n_rd_pend  = 1'b0;
        n_dup      = r_dup;
        n_ov       = r_ov;
        n_new      = r_new;
        n_ev       = r_ev;
        n_fill     = r_fill;
        n_out_new  = r_out_new;
        n_out_ev   = r_out_ev;
        n_out_fill = r_out_fill;
        n_out_dup  = r_out_dup;
        we         = 1'b0;
        waddr      = r_idx[AW-1:0];
        wdata      = r_carry;
        raddr      = r_idx[AW-1:0];
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_key   = i_sequence_req;
                    n_idx   = '0;
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // one read in flight: issue at r_idx, compare on the next cycle
                if (!r_rd_pend) begin
                    if (r_idx >= r_cnt) begin
                        // key goes at the end
                        n_carry = r_key;
                        n_state = ST_SHIFT;
                    end else begin
                        n_rd_pend = 1'b1;
                    end
                end else if (rdata < r_key) begin
                    n_idx = r_idx + 1'b1;
                end else if (rdata == r_key) begin
                    if (r_dup != '1) begin
                        n_dup = r_dup + 1'b1;
                    end
                    n_new   = 1'b0;
                    n_ev    = 1'b0;
                    n_fill  = FILL_W'(r_cnt);
                    n_state = ST_OUT;
                end else begin
                    n_carry = r_key;
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                // write carry at r_idx, pick up the old entry there as new carry
                if (!r_rd_pend && r_idx < r_cnt) begin
                    n_rd_pend = 1'b1;
                end else begin
                    we      = 1'b1;
                    n_carry = rdata;
                    if (r_idx >= r_cnt) begin
                        n_cnt = r_cnt + 1'b1;
                        n_new = 1'b1;
                        if (r_cnt + 1'b1 > CW'(CACHE_SIZE)) begin
                            n_idx   = '0;
                            n_state = ST_EVICT;
                        end else begin
                            n_ev    = 1'b0;
                            n_fill  = FILL_W'(r_cnt + 1'b1);
                            n_state = ST_OUT;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_EVICT: begin
                // copy entry idx+EVICT down to idx
                raddr = AW'(r_idx + CW'(EVICT));
                if (r_idx + CW'(EVICT) >= r_cnt) begin
                    n_cnt   = r_cnt - CW'(EVICT);
                    n_ev    = 1'b1;
                    n_fill  = FILL_W'(r_cnt - CW'(EVICT));
                    n_state = ST_OUT;
                end else if (!r_rd_pend) begin
                    n_rd_pend = 1'b1;
                end else begin
                    we    = 1'b1;
                    wdata = rdata;
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_OUT: begin
                // wait until the output register is free or being emptied
                if (!r_ov || i_ready) begin
                    n_ov       = 1'b1;
                    n_out_new  = r_new;
                    n_out_ev   = r_ev;
                    n_out_fill = r_fill;
                    n_out_dup  = r_dup;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

[hw/rtl/sdf_ram.sv]
// generic single-port-write, single-read ram with registered read data
module sdf_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[tb/sv/testbench.sv]
// testbench for the sequence number duplicate filter
`timescale 1ns / 100ps

module testbench;
    import sdf_pkg::*;

    localparam int unsigned CACHE_SIZE = 64;
    localparam int unsigned EVICT_NUM = CACHE_SIZE / 4;
    localparam int unsigned RANDOM_ITEMS = 800;

    typedef struct packed {
        logic              is_new;
        logic              evicted;
        logic [FILL_W-1:0] fill;
        logic [DUP_W-1:0]  dups;
    } t_verdict;

    typedef struct {
        logic [KEY_W-1:0] key;
        bit               typed;
        t_verdict         verdict;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_ready = 1'b0;
    logic [KEY_W-1:0]   i_sequence_req = '0;
    logic               o_ready;
    logic               o_valid;
    logic               o_is_new;
    logic               o_evicted;
    logic [FILL_W-1:0]  o_fill_level;
    logic [DUP_W-1:0]   o_duplicates_seen;

    logic [KEY_W-1:0]   seen_set[$];
    logic [DUP_W-1:0]   dup_total = '0;
    t_verdict           pending_verdicts[$];
    int unsigned        errors = 0;
    int unsigned        cycle = 0;
    int unsigned        burst_left = 0;

    sequence_duplicate_filter #(.CACHE_SIZE(CACHE_SIZE)) dut (.*);

    always #10 i_clk = ~i_clk;

    // ordered-set model of the filter
    function automatic t_verdict filter_step(logic [KEY_W-1:0] key);
        t_verdict v;
        int unsigned pos;
        pos = 0;
        v = '0;
        while (pos < seen_set.size() && seen_set[pos] < key)
            pos++;
        if (pos < seen_set.size() && seen_set[pos] == key) begin
            if (dup_total != '1)
                dup_total++;
        end else begin
            seen_set.insert(pos, key);
            v.is_new = 1'b1;
            if (seen_set.size() > CACHE_SIZE) begin
                repeat (EVICT_NUM) void'(seen_set.pop_front());
                v.evicted = 1'b1;
            end
        end
        v.fill = FILL_W'(seen_set.size());
        v.dups = dup_total;
        return v;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got,
                                   longint unsigned want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle, field, got, want);
        errors++;
    endtask

    task automatic send_item(logic [KEY_W-1:0] key, bit typed, t_verdict typed_v);
        t_verdict v;
        v = filter_step(key);
        if (typed)
            v = typed_v;
        i_valid <= 1'b1;
        i_sequence_req <= key;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_verdicts = {pending_verdicts, v};
    endtask

    // bursts of items, most of them separated by random gaps
    task automatic pace_sender();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return KEY_W'($urandom_range(0, 300));
        else if (sel < 7 && seen_set.size() > 0)
            return seen_set[$urandom_range(0, seen_set.size() - 1)];
        else if (sel == 7)
            return '1 - KEY_W'($urandom_range(0, 40));
        else
            return {$urandom(), $urandom()};
    endfunction

    // receiver stalls: always ready, coin flip, rotating mask, mostly stalled
    logic [15:0] stall_mask = 16'b1011_0011_1000_1110;
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        stall_mask <= {stall_mask[14:0], stall_mask[15]};
        case ((cycle / 700) % 4)
            0: i_ready <= 1'b1;
            1: i_ready <= $urandom_range(0, 1);
            2: i_ready <= stall_mask[0];
            default: i_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_is_new !== want.is_new) report_mismatch("is_new", o_is_new, want.is_new);
                if (o_evicted !== want.evicted)
                    report_mismatch("evicted", o_evicted, want.evicted);
                if (o_fill_level !== want.fill)
                    report_mismatch("fill_level", o_fill_level, want.fill);
                if (o_duplicates_seen !== want.dups)
                    report_mismatch("duplicates_seen", o_duplicates_seen, want.dups);
            end
        end
    end

    initial begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_row rows[14];
        rows = '{
            '{64'd0, 1'b1, '{1'b1, 1'b0, 7'd1, 32'd0}},
            '{64'd0, 1'b1, '{1'b0, 1'b0, 7'd1, 32'd1}},
            '{'1, 1'b1, '{1'b1, 1'b0, 7'd2, 32'd1}},
            '{64'd1, 1'b1, '{1'b1, 1'b0, 7'd3, 32'd1}},
            '{'1, 1'b1, '{1'b0, 1'b0, 7'd3, 32'd2}},
            '{64'h8000_0000_0000_0000, 1'b1, '{1'b1, 1'b0, 7'd4, 32'd2}},
            '{64'h7fff_ffff_ffff_ffff, 1'b0, '0},
            '{64'h5555_5555_5555_5555, 1'b0, '0},
            '{64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0},
            '{64'd1, 1'b0, '0},
            '{64'd3, 1'b0, '0},
            '{64'd2, 1'b0, '0},
            '{'1 - 64'd1, 1'b0, '0},
            '{64'd0, 1'b0, '0}
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            pace_sender();
            send_item(rows[r].key, rows[r].typed, rows[r].verdict);
        end

        // fill past the cache size so eviction runs early
        for (int k = 0; k < CACHE_SIZE + 4; k++) begin
            pace_sender();
            send_item(KEY_W'(1000 + 3 * k), 1'b0, '0);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                i_valid <= 1'b0;
                while (pending_verdicts.size() != 0) @(posedge i_clk);
            end
            pace_sender();
            send_item(random_key(), 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (3 * CACHE_SIZE + 20) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
